### src/gif_stream_header_parser_core_macros.svh
// Assertion macros shared by the parser RTL
`ifndef GIF_STREAM_HEADER_PARSER_CORE_MACROS_SVH
`define GIF_STREAM_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GHP_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// Next-cycle implication, disabled during reset
`define GHP_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

### src/gifhp_pkg.sv
package gifhp_pkg;

	// Parser phases, one-hot
	typedef enum logic [12:0] {
		PH_SIG   = 13'b0000000000001,
		PH_LSD   = 13'b0000000000010,
		PH_GCT   = 13'b0000000000100,
		PH_BLK   = 13'b0000000001000,
		PH_LABEL = 13'b0000000010000,
		PH_SIZE  = 13'b0000000100000,
		PH_DATA  = 13'b0000001000000,
		PH_TAIL  = 13'b0000010000000,
		PH_SUB   = 13'b0000100000000,
		PH_IMG   = 13'b0001000000000,
		PH_LCT   = 13'b0010000000000,
		PH_START = 13'b0100000000000,
		PH_IDLE  = 13'b1000000000000
	} phase_t;

	// Record kinds
	localparam logic [2:0] KIND_SCREEN     = 3'd0;
	localparam logic [2:0] KIND_COLOR      = 3'd1;
	localparam logic [2:0] KIND_GFX_CTRL   = 3'd2;
	localparam logic [2:0] KIND_COMMENT    = 3'd3;
	localparam logic [2:0] KIND_IMAGE      = 3'd4;
	localparam logic [2:0] KIND_DATA_START = 3'd5;
	localparam logic [2:0] KIND_BAD_HEADER = 3'd6;
	localparam logic [2:0] KIND_NO_DESC    = 3'd7;

	// Block introducers and extension labels
	localparam logic [7:0] BYTE_EXT_INTRO = 8'h21;
	localparam logic [7:0] BYTE_IMG_SEP   = 8'h2c;
	localparam logic [7:0] LBL_GFX_CTRL   = 8'hf9;
	localparam logic [7:0] LBL_COMMENT    = 8'hfe;
	localparam logic [7:0] LBL_PLAIN_TEXT = 8'h01;
	localparam logic [7:0] LBL_APP        = 8'hff;

	// Signature characters
	localparam logic [7:0] CHR_G = 8'h47;
	localparam logic [7:0] CHR_I = 8'h49;
	localparam logic [7:0] CHR_F = 8'h46;
	localparam logic [7:0] CHR_8 = 8'h38;
	localparam logic [7:0] CHR_7 = 8'h37;
	localparam logic [7:0] CHR_9 = 8'h39;
	localparam logic [7:0] CHR_A = 8'h61;

	localparam int TDATA_W = 120;

	typedef struct packed {
		phase_t       phase;
		logic [3:0]   byte_count;
		logic [7:0]   sub_left;
		logic [7:0]   ext_label;
		logic         version;
		logic [3:0]   depth;
		logic [8:0]   table_left;
		logic [63:0]  field_hold;
		logic [15:0]  rgb_hold;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:      PH_SIG,
		byte_count: 4'd0,
		sub_left:   8'd0,
		ext_label:  8'd0,
		version:    1'b0,
		depth:      4'd0,
		table_left: 9'd0,
		field_hold: 64'd0,
		rgb_hold:   16'd0
	};

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] img_left;
		logic [15:0] top_pos;
		logic [7:0]  packed_bits;
		logic [7:0]  byte_a;
		logic [7:0]  aspect;
		logic [23:0] rgb;
		logic [3:0]  color_depth;
		logic        interlaced;
		logic        is_v89;
	} result_t;

endpackage

### src/gifhp_step.sv
module gifhp_step (
	input  gifhp_pkg::parse_state_t cur_state,
	input  logic [7:0]              data_byte,
	input  logic                    frame_start,
	output gifhp_pkg::parse_state_t nxt_state,
	output logic                    emit,
	output gifhp_pkg::result_t      result
);

	// Merge one byte into the held field bytes at the given position
	function automatic logic [63:0] hold_in(logic [63:0] fh, logic [3:0] pos, logic [7:0] b);
		logic [63:0] r;
		r = fh;
		for (int i = 0; i < 8; i++) begin
			if (pos == 4'(i))
				r[8*i +: 8] = fh[8*i +: 8] | b;
		end
		return r;
	endfunction

	gifhp_pkg::parse_state_t st;
	gifhp_pkg::parse_state_t nx;
	gifhp_pkg::result_t      res;
	logic                    em;
	logic [63:0]             fh;
	logic [8:0]              tbl_full;
	logic [8:0]              tbl_idx;
	logic [3:0]              new_depth;
	logic                    sig_ok;
	logic                    ext_runs;

	always_comb begin
		st        = frame_start ? gifhp_pkg::STATE_RESET : cur_state;
		nx        = st;
		res       = '0;
		em        = 1'b0;
		fh        = st.field_hold;
		tbl_full  = 9'd1 << st.depth;
		tbl_idx   = tbl_full - st.table_left;
		new_depth = {1'b0, data_byte[2:0]} + 4'd1;
		sig_ok    = (fh[7:0] == gifhp_pkg::CHR_G) && (fh[15:8] == gifhp_pkg::CHR_I) &&
			(fh[23:16] == gifhp_pkg::CHR_F) && (fh[31:24] == gifhp_pkg::CHR_8) &&
			((fh[39:32] == gifhp_pkg::CHR_7) || (fh[39:32] == gifhp_pkg::CHR_9)) &&
			(data_byte == gifhp_pkg::CHR_A);
		ext_runs  = (st.ext_label == gifhp_pkg::LBL_PLAIN_TEXT) ||
			(st.ext_label == gifhp_pkg::LBL_APP) || (st.ext_label == gifhp_pkg::LBL_COMMENT);

		unique case (st.phase)
			gifhp_pkg::PH_SIG: begin
				if (st.byte_count < 4'd5) begin
					nx.field_hold = hold_in(fh, st.byte_count, data_byte);
					nx.byte_count = st.byte_count + 4'd1;
				end else begin
					nx.byte_count = 4'd0;
					if (sig_ok) begin
						nx.version    = (fh[39:32] == gifhp_pkg::CHR_9);
						nx.field_hold = '0;
						nx.phase      = gifhp_pkg::PH_LSD;
					end else begin
						nx.phase        = gifhp_pkg::PH_IDLE;
						em              = 1'b1;
						res.record_kind = gifhp_pkg::KIND_BAD_HEADER;
					end
				end
			end
			gifhp_pkg::PH_LSD: begin
				if (st.byte_count < 4'd6) begin
					nx.field_hold = hold_in(fh, st.byte_count, data_byte);
					nx.byte_count = st.byte_count + 4'd1;
				end else begin
					nx.byte_count = 4'd0;
					// Global color table present: load its size
					if (fh[39]) begin
						nx.depth      = {1'b0, fh[34:32]} + 4'd1;
						nx.table_left = 9'd1 << nx.depth;
						nx.phase      = gifhp_pkg::PH_GCT;
					end else begin
						nx.phase = gifhp_pkg::PH_BLK;
					end
					em              = 1'b1;
					res.record_kind = gifhp_pkg::KIND_SCREEN;
					res.word_a      = fh[15:0];
					res.word_b      = fh[31:16];
					res.packed_bits = fh[39:32];
					res.byte_a      = fh[47:40];
					res.aspect      = data_byte;
				end
			end
			gifhp_pkg::PH_GCT, gifhp_pkg::PH_LCT: begin
				if (st.byte_count == 4'd0) begin
					nx.rgb_hold   = {data_byte, 8'd0};
					nx.byte_count = 4'd1;
				end else if (st.byte_count == 4'd1) begin
					nx.rgb_hold   = {st.rgb_hold[15:8], data_byte};
					nx.byte_count = 4'd2;
				end else begin
					em              = 1'b1;
					res.record_kind = gifhp_pkg::KIND_COLOR;
					res.word_a      = {7'd0, tbl_idx};
					res.rgb         = {st.rgb_hold, data_byte};
					nx.byte_count   = 4'd0;
					nx.table_left   = st.table_left - 9'd1;
					if (st.table_left == 9'd1)
						nx.phase = (st.phase == gifhp_pkg::PH_GCT) ?
							gifhp_pkg::PH_BLK : gifhp_pkg::PH_START;
				end
			end
			gifhp_pkg::PH_BLK: begin
				if (data_byte == gifhp_pkg::BYTE_EXT_INTRO) begin
					nx.phase = gifhp_pkg::PH_LABEL;
				end else if (data_byte == gifhp_pkg::BYTE_IMG_SEP) begin
					nx.phase      = gifhp_pkg::PH_IMG;
					nx.byte_count = 4'd0;
					nx.field_hold = '0;
				end else begin
					nx.phase        = gifhp_pkg::PH_IDLE;
					em              = 1'b1;
					res.record_kind = gifhp_pkg::KIND_NO_DESC;
				end
			end
			gifhp_pkg::PH_LABEL: begin
				nx.ext_label = data_byte;
				nx.phase     = gifhp_pkg::PH_SIZE;
			end
			gifhp_pkg::PH_SIZE: begin
				nx.sub_left   = data_byte;
				nx.byte_count = 4'd0;
				nx.field_hold = '0;
				nx.phase      = (data_byte == 8'd0) ? gifhp_pkg::PH_TAIL : gifhp_pkg::PH_DATA;
				if (st.ext_label == gifhp_pkg::LBL_COMMENT && st.version) begin
					em              = 1'b1;
					res.record_kind = gifhp_pkg::KIND_COMMENT;
					res.byte_a      = data_byte;
				end
			end
			gifhp_pkg::PH_DATA: begin
				// Keep only the first four data bytes
				if (st.byte_count < 4'd4) begin
					nx.field_hold = hold_in(fh, st.byte_count, data_byte);
					nx.byte_count = st.byte_count + 4'd1;
				end
				nx.sub_left = st.sub_left - 8'd1;
				if (st.sub_left == 8'd1)
					nx.phase = gifhp_pkg::PH_TAIL;
			end
			gifhp_pkg::PH_TAIL: begin
				if (ext_runs) begin
					if (data_byte == 8'd0) begin
						nx.phase = gifhp_pkg::PH_BLK;
					end else begin
						nx.sub_left = data_byte;
						nx.phase    = gifhp_pkg::PH_SUB;
					end
				end else begin
					nx.phase = gifhp_pkg::PH_BLK;
					if (st.ext_label == gifhp_pkg::LBL_GFX_CTRL && st.version) begin
						em              = 1'b1;
						res.record_kind = gifhp_pkg::KIND_GFX_CTRL;
						res.packed_bits = fh[7:0];
						res.word_a      = fh[23:8];
						res.byte_a      = fh[31:24];
					end
				end
			end
			gifhp_pkg::PH_SUB: begin
				nx.sub_left = st.sub_left - 8'd1;
				if (st.sub_left == 8'd1)
					nx.phase = gifhp_pkg::PH_TAIL;
			end
			gifhp_pkg::PH_IMG: begin
				if (st.byte_count < 4'd8) begin
					nx.field_hold = hold_in(fh, st.byte_count, data_byte);
					nx.byte_count = st.byte_count + 4'd1;
				end else begin
					nx.byte_count = 4'd0;
					// Local color table present: load its size
					if (data_byte[7]) begin
						nx.depth      = new_depth;
						nx.table_left = 9'd1 << new_depth;
						nx.phase      = gifhp_pkg::PH_LCT;
					end else begin
						nx.phase = gifhp_pkg::PH_START;
					end
					em              = 1'b1;
					res.record_kind = gifhp_pkg::KIND_IMAGE;
					res.img_left    = fh[15:0];
					res.top_pos     = fh[31:16];
					res.word_a      = fh[47:32];
					res.word_b      = fh[63:48];
					res.packed_bits = data_byte;
					res.interlaced  = data_byte[6];
				end
			end
			gifhp_pkg::PH_START: begin
				nx.phase        = gifhp_pkg::PH_IDLE;
				em              = 1'b1;
				res.record_kind = gifhp_pkg::KIND_DATA_START;
			end
			gifhp_pkg::PH_IDLE: begin
			end
			default: begin
			end
		endcase

		// Every record carries the current depth and version
		res.color_depth = nx.depth;
		res.is_v89      = nx.version;
	end

	assign nxt_state = nx;
	assign emit      = em;
	assign result    = res;

endmodule

### src/gif_stream_header_parser_core.sv
// GIF header parser: one file byte per transaction on the slave side.
// Each accepted byte is captured in the input register, then parsed out of it into
// the result register, from which any record it yields is offered on m_tvalid.
// Throughput: one byte per cycle; only a stalled output record holds the input.
// Reset (arst_n low) clears the parser to await a signature; s_tuser restarts it.
`include "gif_stream_header_parser_core_macros.svh"

module gif_stream_header_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // data_byte
	input  logic                            s_tuser,  // frame_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// word_a, word_b, img_left, top_pos, packed_bits, byte_a, aspect, rgb,
	// color_depth, interlaced, is_v89, zero fill
	output logic [gifhp_pkg::TDATA_W-1:0]   m_tdata,
	output logic [2:0]                      m_tuser   // record_kind
);

	logic                    v_s1;
	logic [7:0]              data_s1;
	logic                    start_s1;
	gifhp_pkg::parse_state_t state_q;
	gifhp_pkg::parse_state_t state_nxt;
	logic                    emit;
	gifhp_pkg::result_t      result;
	gifhp_pkg::result_t      out_q;
	logic                    out_vld_q;
	logic                    advance;
	logic                    rec_is_color;
	logic                    rec_is_bad;

	// Parse the registered byte once the result register can take it
	assign advance  = v_s1 && (!out_vld_q || m_tready);
	assign s_tready = !v_s1 || advance;

	gifhp_step u_step (
		.cur_state   (state_q),
		.data_byte   (data_s1),
		.frame_start (start_s1),
		.nxt_state   (state_nxt),
		.emit        (emit),
		.result      (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// Parser state advances with each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gifhp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= emit;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.record_kind;
	assign m_tdata  = {2'b00, out_q.is_v89, out_q.interlaced, out_q.color_depth, out_q.rgb,
		out_q.aspect, out_q.byte_a, out_q.packed_bits, out_q.top_pos, out_q.img_left,
		out_q.word_b, out_q.word_a};

	// Qualify the offered record by kind
	assign rec_is_color = m_tvalid && (m_tuser == gifhp_pkg::KIND_COLOR);
	assign rec_is_bad   = m_tvalid && (m_tuser == gifhp_pkg::KIND_BAD_HEADER);

	// Input stalls only behind a held output record
	`GHP_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	// A color entry always comes from a loaded table
	`GHP_ASSERT_NOW(a_color_depth, clk, arst_n, rec_is_color, m_tdata[115:112] != 4'd0)
	// A bad header never claims version 89a or interlacing
	`GHP_ASSERT_NOW(a_bad_hdr_ver, clk, arst_n, rec_is_bad, !m_tdata[116] && !m_tdata[117])
	// A record consumed with no new one behind it leaves the output empty
	`GHP_ASSERT_NEXT(a_out_drain, clk, arst_n, m_tvalid && m_tready && !advance, !m_tvalid)

endmodule
